// ===== hw/rtl/ase_pkg.sv =====
// Shared types and fixed constants for the artanh series evaluator.
// Depends on nothing; used by ase_div and artanh_series_evaluator_unit.
package ase_pkg;

	localparam int MAG_W   = 32;
	localparam int SUM_W   = 40;
	localparam int TERMS_W = 11;
	localparam int TOL_W   = 30;

	localparam logic [TOL_W-1:0] TOL_RESET = 30'd1074;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] dividend;
	} div_req_t;

endpackage

// ===== hw/rtl/ase_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ase_pkg (div_req_t, MAG_W).
module ase_div #(
	parameter int DIV_W = 11
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ase_pkg::div_req_t         req,
	input  logic [DIV_W-1:0]          divisor,
	output logic                      done,
	output logic [ase_pkg::MAG_W-1:0] quotient
);

	localparam int STEP_W = $clog2(ase_pkg::MAG_W);

	logic                      busy_q;
	logic                      done_q;
	logic [STEP_W-1:0]         step_q;
	logic [DIV_W-1:0]          dvs_q;
	logic [DIV_W-1:0]          rem_q;
	logic [ase_pkg::MAG_W-1:0] quo_q;

	logic [DIV_W:0] rem_sh;
	logic [DIV_W:0] rem_sub;
	logic           ge;

	always_comb begin
		rem_sh  = {rem_q, quo_q[ase_pkg::MAG_W-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(ase_pkg::MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			quo_q <= {quo_q[ase_pkg::MAG_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/artanh_series_evaluator_unit.sv =====
// artanh Taylor series evaluator: sequencer, shared multiplier and accumulator.
// Depends on ase_pkg and ase_div.
//
//  channel | signals                       | dir | moves
//  --------+-------------------------------+-----+--------------------------------------
//  in      | in_valid in_stall arg_x       | in  | one argument word
//  out     | out_valid out_stall sum_value | out | result word, terms_used diverged hit_limit
//  cfg     | cfg_valid cfg_ready cfg_data  | in  | tolerance register word
//
// An argument holds the unit until its series is done: after loading and forming x squared,
// each term takes a divider start, the bit-serial divide and one accumulate, plus
// a multiply and a power update before all but the last. A diverging argument skips
// the series and goes straight to the result. in_stall is high from acceptance until the
// result is loaded into the output register; a stalled result holds the last step.
// Reset clears the sequencer and output valid and sets tolerance to 1074.
module artanh_series_evaluator_unit #(
	parameter int MAX_TERMS = 1024,
	parameter int FRAC_BITS = 30
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [ase_pkg::MAG_W-1:0]   arg_x,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [ase_pkg::SUM_W-1:0]   sum_value,
	output logic        [ase_pkg::TERMS_W-1:0] terms_used,
	output logic                               diverged,
	output logic                               hit_limit,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic        [ase_pkg::TOL_W-1:0]   cfg_data
);

	localparam int MAG_W = ase_pkg::MAG_W;
	localparam int SUM_W = ase_pkg::SUM_W;
	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int DIV_W = $clog2(2 * MAX_TERMS);
	localparam logic [2*MAG_W-1:0] ONE = (2*MAG_W)'(1) << FRAC_BITS;
	localparam logic [SUM_W:0] SAT_POS = {2'b00, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W:0] SAT_NEG = {2'b01, {(SUM_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQR, ST_X2, ST_DSTART, ST_DWAIT, ST_ACC, ST_MUL, ST_POW, ST_FIN
	} state_t;

	state_t state_q;

	logic [ase_pkg::TOL_W-1:0] tol_q;
	logic                      neg_q;
	logic                      div_flag_q;
	logic                      lim_q;
	logic [MAG_W-1:0]          mag_q;
	logic [MAG_W-1:0]          x2_q;
	logic [MAG_W-1:0]          pw_q;
	logic [2*MAG_W-1:0]        prod_q;
	logic [SUM_W-1:0]          sum_q;
	logic [CNT_W-1:0]          cnt_q;

	logic                            out_valid_q;
	logic [SUM_W-1:0]                sum_value_q;
	logic [ase_pkg::TERMS_W-1:0]     terms_used_q;
	logic                            diverged_q;
	logic                            hit_limit_q;

	logic [MAG_W-1:0]   arg_u;
	logic [MAG_W-1:0]   mag_in;
	logic               big_in;
	logic [MAG_W-1:0]   mul_a;
	logic [MAG_W-1:0]   mul_b;
	logic [MAG_W-1:0]   prod_sh;
	logic [SUM_W:0]     sum_add;
	logic [SUM_W:0]     sat_lim;
	logic [SUM_W-1:0]   sum_nx;
	logic [CNT_W-1:0]   cnt_nx;
	logic               out_free;

	ase_pkg::div_req_t  div_req;
	logic [DIV_W-1:0]   divisor;
	logic               div_done;
	logic [MAG_W-1:0]   div_quo;

	always_comb begin
		arg_u    = unsigned'(arg_x);
		mag_in   = arg_u[MAG_W-1] ? (~arg_u + 1'b1) : arg_u;
		big_in   = {{MAG_W{1'b0}}, mag_in} >= ONE;
		mul_a    = (state_q == ST_SQR) ? mag_q : pw_q;
		mul_b    = (state_q == ST_SQR) ? mag_q : x2_q;
		prod_sh  = MAG_W'(prod_q >> FRAC_BITS);
		sum_add  = {1'b0, sum_q} + (SUM_W+1)'(div_quo);
		sat_lim  = neg_q ? SAT_NEG : SAT_POS;
		sum_nx   = (sum_add > sat_lim) ? sat_lim[SUM_W-1:0] : sum_add[SUM_W-1:0];
		cnt_nx   = cnt_q + 1'b1;
		out_free = !out_valid_q || !out_stall;
		divisor  = {cnt_q[DIV_W-2:0], 1'b1};
		div_req.start    = (state_q == ST_DSTART);
		div_req.dividend = pw_q;
	end

	ase_div #(
		.DIV_W (DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= ase_pkg::TOL_RESET;
		end else if (cfg_valid) begin
			tol_q       <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= big_in ? ST_FIN : ST_SQR;
					end
				end
				ST_SQR:    state_q <= ST_X2;
				ST_X2:     state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_done)
						state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (div_quo <= {2'b00, tol_q} || cnt_nx >= CNT_W'(MAX_TERMS))
						state_q <= ST_FIN;
					else
						state_q <= ST_MUL;
				end
				ST_MUL:    state_q <= ST_POW;
				ST_POW:    state_q <= ST_DSTART;
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				neg_q      <= arg_u[MAG_W-1];
				mag_q      <= mag_in;
				pw_q       <= mag_in;
				div_flag_q <= big_in;
				sum_q      <= '0;
				cnt_q      <= '0;
				lim_q      <= 1'b0;
			end
			ST_SQR:  prod_q <= mul_a * mul_b;
			ST_X2:   x2_q   <= prod_sh;
			ST_ACC: begin
				sum_q <= sum_nx;
				cnt_q <= cnt_nx;
				lim_q <= !(div_quo <= {2'b00, tol_q}) && cnt_nx >= CNT_W'(MAX_TERMS);
			end
			ST_MUL:  prod_q <= mul_a * mul_b;
			ST_POW:  pw_q   <= prod_sh;
			ST_FIN: begin
				if (out_free) begin
					sum_value_q  <= neg_q ? (~sum_q + 1'b1) : sum_q;
					terms_used_q <= ase_pkg::TERMS_W'(cnt_q);
					diverged_q   <= div_flag_q;
					hit_limit_q  <= lim_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign sum_value  = signed'(sum_value_q);
	assign terms_used = terms_used_q;
	assign diverged   = diverged_q;
	assign hit_limit  = hit_limit_q;

endmodule

// ===== hw/rtl/ase_chk.sv =====
// Port-level checks for artanh_series_evaluator_unit, bound to the top level.
// Depends on ase_pkg for field widths.
module ase_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [ase_pkg::SUM_W-1:0]   sum_value,
	input logic        [ase_pkg::TERMS_W-1:0] terms_used,
	input logic                               diverged,
	input logic                               hit_limit
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block took a second word straight after the first");

	a_diverged_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && diverged |-> sum_value == 0 && terms_used == 0 && !hit_limit)
		else $error("diverged word carries a non-zero sum, count or limit");

	a_terms_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !diverged |-> terms_used != 0)
		else $error("converging word reports no terms");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sum_value) && $stable(terms_used))
		else $error("stalled result word changed");

endmodule

bind artanh_series_evaluator_unit ase_chk u_ase_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.sum_value  (sum_value),
	.terms_used (terms_used),
	.diverged   (diverged),
	.hit_limit  (hit_limit)
);

// ===== bench/artanh_series_evaluator_unit_test.sv =====
// Self-checking bench for artanh_series_evaluator_unit: directed and random arguments,
// with tolerance rewrites between phases. Each word is checked against a local series model.
// Depends on ase_pkg and the evaluator RTL only.
`timescale 1ns / 100ps

module artanh_series_evaluator_unit_test;

	localparam int MAX_TERMS    = 1024;
	localparam int FRAC_BITS    = 30;
	localparam int SETTLE       = 8;
	localparam int REPORT_MAX   = 10;
	localparam int IDLE_PCT     = 13;
	localparam int HEAVY_TERMS  = 64;
	localparam logic [63:0] POS_CAP = (64'd1 << (ase_pkg::SUM_W-1)) - 64'd1;
	localparam logic [63:0] NEG_CAP = 64'd1 << (ase_pkg::SUM_W-1);
	localparam logic [32:0] ONE_MAG = 33'd1 << FRAC_BITS;

	typedef struct packed {
		logic [ase_pkg::SUM_W-1:0]   sum;
		logic [ase_pkg::TERMS_W-1:0] terms;
		logic                        diverged;
		logic                        hit_limit;
	} artanh_word_t;

	typedef enum logic [1:0] {PEND_ARG, PEND_TOL, PEND_DRAIN} pend_kind_t;

	typedef struct {
		pend_kind_t  kind;
		logic [31:0] word;
	} pend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [ase_pkg::MAG_W-1:0] arg_x = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [ase_pkg::SUM_W-1:0] sum_value;
	logic [ase_pkg::TERMS_W-1:0] terms_used;
	logic diverged;
	logic hit_limit;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ase_pkg::TOL_W-1:0] cfg_data = '0;

	pend_t          pending[$];
	artanh_word_t   sums_due[$];
	logic           in_fire = 1'b0;
	logic           cfg_fire = 1'b0;
	logic           calm = 1'b0;
	logic [ase_pkg::TOL_W-1:0] tol_now = ase_pkg::TOL_RESET;
	logic [ase_pkg::TOL_W-1:0] fill_tol = ase_pkg::TOL_RESET;
	bit             draining = 1'b0;
	int             hold = 0;
	int             args_sent = 0;
	int             faults = 0;
	int             words_checked = 0;
	int             div_seen = 0;
	int             cap_seen = 0;
	int             most_terms = 0;
	int             tol_writes = 0;
	longint         cycles = 0;
	longint         cycle_limit = 64'd1 << 40;
	longint         budget = 0;

	artanh_series_evaluator_unit #(
		.MAX_TERMS(MAX_TERMS),
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.arg_x(arg_x),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sum_value(sum_value),
		.terms_used(terms_used),
		.diverged(diverged),
		.hit_limit(hit_limit),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [63:0] frac_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[FRAC_BITS+63:FRAC_BITS];
	endfunction

	// magnitudes throughout, sign of x applied to the final sum
	function automatic artanh_word_t artanh_series(input logic [31:0] x,
			input logic [ase_pkg::TOL_W-1:0] tol);
		artanh_word_t r;
		logic neg;
		logic [32:0] mag;
		logic [63:0] x2, pw, term, acc;
		int n;
		bit done;
		r = '0;
		neg = x[31];
		mag = neg ? (33'h1_0000_0000 - {1'b0, x}) : {1'b0, x};
		if (mag >= ONE_MAG) begin
			r.diverged = 1'b1;
			return r;
		end
		pw = {31'd0, mag};
		x2 = frac_mul(pw, pw);
		acc = '0;
		n = 0;
		done = 1'b0;
		while (!done) begin
			term = pw / (64'd2 * n + 64'd1);
			acc = acc + term;
			if (neg && acc > NEG_CAP)
				acc = NEG_CAP;
			else if (!neg && acc > POS_CAP)
				acc = POS_CAP;
			n++;
			if (term <= {34'd0, tol}) begin
				done = 1'b1;
			end else if (n >= MAX_TERMS) begin
				r.hit_limit = 1'b1;
				done = 1'b1;
			end else begin
				pw = frac_mul(pw, x2);
			end
		end
		r.sum = neg ? (40'd0 - acc[ase_pkg::SUM_W-1:0]) : acc[ase_pkg::SUM_W-1:0];
		r.terms = n[ase_pkg::TERMS_W-1:0];
		return r;
	endfunction

	task automatic push_arg(input logic [31:0] x);
		artanh_word_t w;
		w = artanh_series(x, fill_tol);
		budget += 2 + 37 * longint'(w.terms) + 24;
		pending.push_back('{PEND_ARG, x});
	endtask

	// tolerance only changes with the unit idle
	task automatic push_tol(input logic [31:0] v);
		pending.push_back('{PEND_DRAIN, 32'd0});
		pending.push_back('{PEND_TOL, v});
		fill_tol = v[ase_pkg::TOL_W-1:0];
		budget += 200;
	endtask

	// driver
	always @(negedge clk) begin : drive
		pend_t it;
		logic nv_in, nv_cfg;
		nv_in = in_valid;
		nv_cfg = cfg_valid;
		if (arst_n) begin
			if (in_fire)
				nv_in = 1'b0;
			if (cfg_fire)
				nv_cfg = 1'b0;
			if (nv_in || nv_cfg) begin
			end else if (hold > 0) begin
				hold--;
			end else if (draining) begin
				if (sums_due.size() == 0) begin
					draining = 1'b0;
					hold = SETTLE;
				end
			end else if (pending.size() > 0 &&
					(calm || $urandom_range(99) >= IDLE_PCT)) begin
				it = pending.pop_front();
				case (it.kind)
					PEND_ARG: begin
						nv_in = 1'b1;
						arg_x <= it.word;
						args_sent++;
					end
					PEND_TOL: begin
						nv_cfg = 1'b1;
						cfg_data <= it.word[ase_pkg::TOL_W-1:0];
					end
					default: begin
						draining = 1'b1;
					end
				endcase
			end
			calm <= (args_sent >= 70 && args_sent < 110);
		end
		in_valid <= nv_in;
		cfg_valid <= nv_cfg;
	end

	always @(negedge clk)
		out_stall <= arst_n && !calm && ($urandom_range(99) < IDLE_PCT);

	// monitor and scoreboard
	always @(posedge clk) begin : observe
		artanh_word_t want;
		logic bad;
		cycles = cycles + 1;
		if (cycles > cycle_limit) begin
			$display("timeout at cycle %0d with %0d words outstanding", cycles,
				sums_due.size());
			$display("*** FAILED ***");
			$finish;
		end else if (arst_n) begin
			in_fire <= in_valid && !in_stall;
			cfg_fire <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready) begin
				tol_now = cfg_data;
				tol_writes++;
			end
			if (in_valid && !in_stall)
				sums_due.push_back(artanh_series(arg_x, tol_now));
			if (out_valid && !out_stall) begin
				if (sums_due.size() == 0) begin
					faults++;
					if (faults <= REPORT_MAX)
						$display("unexpected word at cycle %0d: sum %0d terms %0d",
							cycles, sum_value, terms_used);
				end else begin
					want = sums_due.pop_front();
					words_checked++;
					div_seen += int'(want.diverged);
					cap_seen += int'(want.hit_limit);
					if (int'(want.terms) > most_terms)
						most_terms = int'(want.terms);
					bad = (sum_value !== $signed(want.sum)) || (terms_used !== want.terms)
						|| (diverged !== want.diverged) || (hit_limit !== want.hit_limit);
					if (bad) begin
						faults++;
						if (faults <= REPORT_MAX)
							$display({"word %0d: exp sum %0d terms %0d div %b cap %b,",
								" got sum %0d terms %0d div %b cap %b"},
								words_checked, $signed(want.sum), want.terms,
								want.diverged, want.hit_limit, sum_value, terms_used,
								diverged, hit_limit);
					end
				end
			end
		end
	end

	initial begin : run
		logic [31:0] v;
		logic [31:0] phase_tol[4];
		artanh_word_t w;
		int pick, heavy_left;
		bit heavy;

		// directed: zero, smallest steps, the unit boundary, range ends, term cap
		push_arg(32'h0000_0000);
		push_arg(32'h0000_0001);
		push_arg(32'hFFFF_FFFF);
		push_arg(32'h4000_0000);
		push_arg(32'hC000_0000);
		push_arg(32'h3FFF_FFFF);
		push_arg(32'hC000_0001);
		push_arg(32'h7FFF_FFFF);
		push_arg(32'h8000_0000);
		push_arg(32'h2000_0000);
		push_arg(32'hE000_0000);
		push_arg(32'd966367642);
		// first term exactly at, then just above, the tolerance
		push_arg(32'd1074);
		push_arg(32'd1075);
		push_tol(32'h3FFF_FFFF);
		push_arg(32'h3FFF_FFFF);
		push_arg(32'hD000_0000);
		push_tol(32'd1);
		push_arg(32'd322122547);
		push_arg(-32'sd644245094);
		push_arg(32'd858993459);

		phase_tol[0] = 32'd1074;
		phase_tol[1] = $urandom_range(2, 32'h0000_FFFF);
		phase_tol[2] = $urandom_range(1, 32'h3FFF_FFFF);
		phase_tol[3] = 32'd1;
		heavy_left = 3;
		for (int ph = 0; ph < 4; ph++) begin
			push_tol(phase_tol[ph]);
			for (int i = 0; i < 30; i++) begin
				if (ph == 1 && i == 15)
					pending.push_back('{PEND_DRAIN, 32'd0});
				do begin
					pick = $urandom_range(99);
					if (pick < 30) begin
						do
							v = $urandom;
						while (v[31] ? (v > 32'hC000_0000) : (v < 32'h4000_0000));
					end else begin
						if (pick < 85)
							v = $urandom_range(0, 32'h3FFF_FFFF);
						else if (pick < 95)
							v = $urandom_range(0, 4095);
						else
							v = 32'h4000_0000 - $urandom_range(1, 32'h0040_0000);
						if ($urandom_range(1))
							v = -v;
					end
					w = artanh_series(v, fill_tol);
					heavy = int'(w.terms) > HEAVY_TERMS;
				end while (heavy && heavy_left == 0);
				if (heavy)
					heavy_left--;
				push_arg(v);
			end
		end
		cycle_limit = 4 * budget + 50000;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || in_valid || cfg_valid || sums_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (sums_due.size() != 0)
			faults += sums_due.size();

		$display("%0d arguments sent, %0d words checked: %0d diverged, %0d at term cap,",
			args_sent, words_checked, div_seen, cap_seen);
		$display("longest series %0d terms, %0d tolerance writes, %0d faults",
			most_terms, tol_writes, faults);
		if (faults == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
